// File: rtl/l24pc_pkg.sv
// Shared types and constants for the L24 payload pattern checker.
// No dependencies; every other file in rtl/ imports this package.
package l24pc_pkg;

   localparam int BYTE_W   = 8;
   localparam int SAMPLE_W = 24;
   localparam int FRAME_W  = 32;
   localparam int COUNT_W  = 16;

   // Pattern multipliers; only the low sample bits matter after the mask
   localparam logic [FRAME_W-1:0] FRAME_MUL = 32'd2654435761;
   localparam logic [FRAME_W-1:0] CHAN_MUL  = 32'h9E3779B9;

   // Byte position in a sample that completes it
   localparam logic [1:0] POS_LAST = 2'd2;

   // One report word from the tally stage to the response buffer
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] error_count;
   } result_type;

endpackage

// File: rtl/l24pc_req_if.sv
// Request channel: one payload byte per word with packet markers.
// Depends on l24pc_pkg.
interface l24pc_req_if;
   import l24pc_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic               start_of_packet;
   logic [FRAME_W-1:0] frame_base;
   logic               end_of_packet;

   modport source (output valid, data_byte, start_of_packet, frame_base, end_of_packet,
                   input ready);
   modport sink   (input valid, data_byte, start_of_packet, frame_base, end_of_packet,
                   output ready);
endinterface

// File: rtl/l24pc_rsp_if.sv
// Response channel: one error count word per packet.
// Depends on l24pc_pkg.
interface l24pc_rsp_if;
   import l24pc_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] error_count;

   modport source (output valid, error_count, input ready);
   modport sink   (input valid, error_count, output ready);
endinterface

// File: rtl/l24pc_expect.sv
// Expected-sample generator: registers the pattern for the current
// frame and channel. Depends on l24pc_pkg.
module l24pc_expect #(
   parameter int CHAN_W = 1
) (
   input  logic                          clock,
   input  logic [l24pc_pkg::FRAME_W-1:0] frame_number,
   input  logic [CHAN_W-1:0]             channel_index,
   output logic [l24pc_pkg::SAMPLE_W-1:0] expected
);
   import l24pc_pkg::*;

   logic [SAMPLE_W-1:0] frame_term;
   logic [SAMPLE_W-1:0] chan_term;
   logic [SAMPLE_W-1:0] expected_ff;
   logic [SAMPLE_W-1:0] expected_in;

   // Only the low 24 bits of each product survive the mask
   assign frame_term  = SAMPLE_W'(frame_number[SAMPLE_W-1:0] * FRAME_MUL[SAMPLE_W-1:0]);
   assign chan_term   = SAMPLE_W'(CHAN_MUL[SAMPLE_W-1:0] * SAMPLE_W'(channel_index));
   assign expected_in = frame_term ^ chan_term;

   // Refreshed every cycle; state settles at least two bytes before a compare
   always_ff @(posedge clock) begin
      expected_ff <= expected_in;
   end

   assign expected = expected_ff;

endmodule

// File: rtl/l24pc_tally.sv
// Byte assembly, sample compare and per-frame error tally.
// Depends on l24pc_pkg.
module l24pc_tally #(
   parameter int CHANNELS   = 2,
   parameter int ERROR_BITS = 16,
   parameter int CHAN_W     = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [l24pc_pkg::BYTE_W-1:0]   data_byte,
   input  logic                           start_of_packet,
   input  logic [l24pc_pkg::FRAME_W-1:0]  frame_base,
   input  logic                           end_of_packet,
   input  logic [l24pc_pkg::SAMPLE_W-1:0] expected,
   output logic [l24pc_pkg::FRAME_W-1:0]  frame_number,
   output logic [CHAN_W-1:0]              channel_index,
   output l24pc_pkg::result_type          result
);
   import l24pc_pkg::*;

   localparam int MISS_W = $clog2(CHANNELS + 1);
   localparam int SUM_W  = ERROR_BITS + 1;
   localparam int PART_W = SAMPLE_W - BYTE_W;

   logic [1:0]            pos_ff,     pos_in;
   logic [CHAN_W-1:0]     chan_ff,    chan_in;
   logic [FRAME_W-1:0]    frame_ff,   frame_in;
   logic [PART_W-1:0]     partial_ff, partial_in;
   logic [MISS_W-1:0]     miss_ff,    miss_in;
   logic [ERROR_BITS-1:0] total_ff,   total_in;

   // Packet state as seen by this byte (cleared by a start byte)
   logic [1:0]            pos_cur;
   logic [CHAN_W-1:0]     chan_cur;
   logic [FRAME_W-1:0]    frame_cur;
   logic [PART_W-1:0]     partial_cur;
   logic [MISS_W-1:0]     miss_cur;
   logic [ERROR_BITS-1:0] total_cur;

   logic [SAMPLE_W-1:0]   sample;
   logic                  mismatch;
   logic [MISS_W-1:0]     miss_sum;
   logic [SUM_W-1:0]      total_sum;
   logic [ERROR_BITS-1:0] total_sat;

   assign pos_cur     = start_of_packet ? '0 : pos_ff;
   assign chan_cur    = start_of_packet ? '0 : chan_ff;
   assign frame_cur   = start_of_packet ? frame_base : frame_ff;
   assign partial_cur = start_of_packet ? '0 : partial_ff;
   assign miss_cur    = start_of_packet ? '0 : miss_ff;
   assign total_cur   = start_of_packet ? '0 : total_ff;

   // Sample compare and saturating frame add
   assign sample    = {partial_cur, data_byte};
   assign mismatch  = (sample != expected);
   assign miss_sum  = miss_cur + MISS_W'(mismatch);
   assign total_sum = SUM_W'(total_cur) + SUM_W'(miss_sum);
   assign total_sat = total_sum[ERROR_BITS] ? '1 : total_sum[ERROR_BITS-1:0];

   // Next state
   always_comb begin
      pos_in     = pos_cur;
      chan_in    = chan_cur;
      frame_in   = frame_cur;
      partial_in = partial_cur;
      miss_in    = miss_cur;
      total_in   = total_cur;
      if (pos_cur != POS_LAST) begin
         partial_in = {partial_cur[PART_W-BYTE_W-1:0], data_byte};
         pos_in     = pos_cur + 2'd1;
      end else begin
         pos_in     = '0;
         partial_in = '0;
         if (chan_cur == CHAN_W'(CHANNELS - 1)) begin
            total_in = total_sat;
            miss_in  = '0;
            chan_in  = '0;
            frame_in = frame_cur + FRAME_W'(1);
         end else begin
            miss_in  = miss_sum;
            chan_in  = chan_cur + CHAN_W'(1);
         end
      end
      // Report word carries the total before the end-of-packet clear
      result.valid       = end_of_packet;
      result.error_count = COUNT_W'(total_in);
      if (end_of_packet) begin
         pos_in     = '0;
         chan_in    = '0;
         partial_in = '0;
         miss_in    = '0;
         total_in   = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         chan_ff  <= '0;
         frame_ff <= '0;
         miss_ff  <= '0;
         total_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         frame_ff <= frame_in;
         miss_ff  <= miss_in;
         total_ff <= total_in;
      end
   end

   // Sample bytes; reset to zero to match the packet-clear state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
      end
   end

   assign frame_number  = frame_ff;
   assign channel_index = chan_ff;

endmodule

// File: rtl/l24pc_rsp_buf.sv
// Response output register with one skid entry.
// Depends on l24pc_pkg and l24pc_rsp_if.
module l24pc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  l24pc_pkg::result_type result,
   output logic                  take_ready,
   l24pc_rsp_if.source           rsp_if
);
   import l24pc_pkg::*;

   logic               out_valid_ff;
   logic [COUNT_W-1:0] out_data_ff;
   logic               skid_valid_ff;
   logic [COUNT_W-1:0] skid_data_ff;
   logic               drain;

   // Output register frees when empty or taken this cycle
   assign drain = !out_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= result.valid;
         end
      end else if (result.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result.error_count;
      end
      if (!drain && result.valid) begin
         skid_data_ff <= result.error_count;
      end
   end

   // Input side holds off only while the skid entry is occupied
   assign take_ready         = !skid_valid_ff;
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.error_count = out_data_ff;

endmodule

// File: rtl/l24_pattern_payload_checker.sv
// L24 payload pattern checker, top level.
// Depends on l24pc_pkg, l24pc_req_if, l24pc_rsp_if, l24pc_expect,
// l24pc_tally and l24pc_rsp_buf.
//
// req_if takes one payload byte per word, with start_of_packet on the first
// byte (frame_base sampled there) and end_of_packet on the last. Every three
// bytes form a big-endian 24-bit sample, CHANNELS samples to a frame; each is
// checked against the frame/channel pattern. Mismatches count only for
// complete frames. On an end_of_packet byte one word leaves on rsp_if with
// the saturated error total; other bytes give no response.
// Throughput: one byte per cycle while req_if.ready is high. The tally state updates in the cycle the
// byte is taken; the expected pattern comes from a registered 24x24 multiply
// that is refreshed every cycle, ready by the time the third byte of a sample
// arrives.
// Response path: the word is registered in the output register, or in the skid entry while rsp_if stalls.
// Stall: the output register plus one skid entry absorb a stalled receiver;
// req_if.ready drops only while the skid entry is full.
// Reset (synchronous): all packet state, the frame number and both response
// entries clear. Bytes without a preceding start byte continue the old state.
module l24_pattern_payload_checker #(
   parameter int CHANNELS   = 2,
   parameter int ERROR_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   l24pc_req_if.sink    req_if,
   l24pc_rsp_if.source  rsp_if
);
   import l24pc_pkg::*;

   localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                req_accept;
   logic                take_ready;
   logic [FRAME_W-1:0]  frame_number;
   logic [CHAN_W-1:0]   channel_index;
   logic [SAMPLE_W-1:0] expected;
   result_type          result;
   result_type          result_gated;

   assign req_if.ready = take_ready;
   assign req_accept   = req_if.valid && take_ready;

   l24pc_expect #(
      .CHAN_W (CHAN_W)
   ) u_expect (
      .clock         (clock),
      .frame_number  (frame_number),
      .channel_index (channel_index),
      .expected      (expected)
   );

   l24pc_tally #(
      .CHANNELS   (CHANNELS),
      .ERROR_BITS (ERROR_BITS),
      .CHAN_W     (CHAN_W)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .data_byte       (req_if.data_byte),
      .start_of_packet (req_if.start_of_packet),
      .frame_base      (req_if.frame_base),
      .end_of_packet   (req_if.end_of_packet),
      .expected        (expected),
      .frame_number    (frame_number),
      .channel_index   (channel_index),
      .result          (result)
   );

   // A report exists only for an accepted end byte
   always_comb begin
      result_gated       = result;
      result_gated.valid = result.valid && req_accept;
   end

   l24pc_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .result     (result_gated),
      .take_ready (take_ready),
      .rsp_if     (rsp_if)
   );

   // An accepted end byte always shows a response word next cycle
   a_eop_response: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.end_of_packet) |=> rsp_if.valid)
      else $error("end byte produced no response word");

   // Input back-pressure only while both response entries are full
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("input stalled with empty output register");

   // Reset empties the response side
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule
